[src/dsrs_pkg.sv]
`default_nettype none
package dsrs_pkg;

    localparam int COORD_W = 12;
    localparam int DEPTH_W = 24;
    localparam int FX_W    = 20;
    localparam int ROWS_W  = 13;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 24;

    localparam logic [FX_W-1:0]          FOCAL_X_RST      = 20'd142263;
    localparam logic [FX_W-1:0]          CENTER_X_RST     = 20'd88761;
    localparam logic [ROWS_W-1:0]        STRIP_HEIGHT_RST = 13'd10;
    localparam logic signed [ROWS_W-1:0] STRIP_ROW_AUTO   = -13'sd1;
    localparam logic [ROWS_W-1:0]        IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [DEPTH_W-1:0]       DEPTH_LO_RST     = 24'd6554;
    localparam logic [DEPTH_W-1:0]       DEPTH_HI_RST     = 24'd1310720;

    typedef enum logic [CFG_AW-1:0] {
        CFG_FOCAL_X      = 3'd0,
        CFG_CENTER_X     = 3'd1,
        CFG_STRIP_HEIGHT = 3'd2,
        CFG_STRIP_ROW    = 3'd3,
        CFG_IMAGE_HEIGHT = 3'd4,
        CFG_DEPTH_LO     = 3'd5,
        CFG_DEPTH_HI     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [FX_W-1:0]          focal_x;
        logic [FX_W-1:0]          center_x;
        logic [ROWS_W-1:0]        strip_height;
        logic signed [ROWS_W-1:0] strip_row;
        logic [ROWS_W-1:0]        image_height;
        logic [DEPTH_W-1:0]       depth_lo;
        logic [DEPTH_W-1:0]       depth_hi;
    } t_cfg;

    typedef struct packed {
        logic               vld;
        logic [COORD_W-1:0] col;
        logic [DEPTH_W-1:0] depth;
        logic               ok;
    } t_col_res;

    typedef struct packed {
        logic               vld;
        logic [COORD_W-1:0] col;
        logic [DEPTH_W-1:0] range;
        logic               fin;
    } t_scan;

endpackage
`default_nettype wire

[src/dsrs_ram.sv]
`default_nettype none
module dsrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[src/dsrs_column.sv]
`default_nettype none
module dsrs_column #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  dsrs_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    input  logic [dsrs_pkg::COORD_W-1:0]      i_row,
    input  logic [dsrs_pkg::COORD_W-1:0]      i_col,
    input  logic [dsrs_pkg::DEPTH_W-1:0]      i_depth,
    input  logic                              i_fin,
    output dsrs_pkg::t_col_res                o_res
);
    import dsrs_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic               vld;
        logic [DEPTH_W-1:0] dmin;
    } t_entry;

    logic signed [14:0] w_c, w_half, w_rs_raw, w_re_raw, w_rs, w_re, w_row, w_ih;
    logic               w_col_ok, w_in_strip, w_first, w_last, w_usable;

    always_comb begin
        if (i_cfg.strip_row == STRIP_ROW_AUTO) begin
            w_c = signed'({3'b0, i_cfg.image_height[ROWS_W-1:1]});
        end else begin
            w_c = 15'(signed'(i_cfg.strip_row));
        end
        w_half   = signed'({3'b0, i_cfg.strip_height[ROWS_W-1:1]});
        w_ih     = signed'({2'b0, i_cfg.image_height});
        w_rs_raw = w_c - w_half;
        w_re_raw = w_c + w_half;
        w_rs     = (w_rs_raw < 15'sd0) ? 15'sd0 : w_rs_raw;
        w_re     = (w_re_raw > w_ih) ? w_ih : w_re_raw;
        w_row    = signed'({3'b0, i_row});
        w_col_ok = {1'b0, i_col} < 13'(MAX_WIDTH);
        w_in_strip = (w_re > w_rs) && (w_row >= w_rs) && (w_row < w_re) && w_col_ok;
        w_first  = (w_row == w_rs);
        w_last   = (w_row == (w_re - 15'sd1));
        w_usable = i_fin && (i_depth > i_cfg.depth_lo) && (i_depth < i_cfg.depth_hi);
    end

    logic               r_v, r_first, r_last, r_usable;
    logic [AW-1:0]      r_addr;
    logic [COORD_W-1:0] r_col;
    logic [DEPTH_W-1:0] r_z;
    logic               r_fw_v;
    logic [AW-1:0]      r_fw_addr;
    t_entry             r_fw_data;
    t_col_res           r_res;
    t_entry             w_rdata, w_old, w_new;

    dsrs_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_en && r_v),
        .i_waddr (r_addr),
        .i_wdata (w_new),
        .i_re    (i_en),
        .i_raddr (i_col[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_old = (r_fw_v && (r_fw_addr == r_addr)) ? r_fw_data : w_rdata;
        if (r_first) begin
            w_new.vld  = r_usable;
            w_new.dmin = r_usable ? r_z : '0;
        end else if (r_usable && (!w_old.vld || (r_z < w_old.dmin))) begin
            w_new.vld  = 1'b1;
            w_new.dmin = r_z;
        end else begin
            w_new = w_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= 1'b0;
            r_fw_v    <= 1'b0;
            r_res.vld <= 1'b0;
        end else if (i_en) begin
            r_v       <= i_valid && w_in_strip;
            r_fw_v    <= r_v;
            r_res.vld <= r_v && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first   <= w_first;
            r_last    <= w_last;
            r_usable  <= w_usable;
            r_addr    <= i_col[AW-1:0];
            r_col     <= i_col;
            r_z       <= i_depth;
            r_fw_addr <= r_addr;
            r_fw_data <= w_new;
            r_res.col   <= r_col;
            r_res.depth <= w_new.dmin;
            r_res.ok    <= w_new.vld;
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

[src/dsrs_range.sv]
`default_nettype none
module dsrs_range (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  dsrs_pkg::t_cfg     i_cfg,
    input  dsrs_pkg::t_col_res i_res,
    output dsrs_pkg::t_scan    o_scan
);
    import dsrs_pkg::*;

    localparam int SQ_N = 32;
    localparam int DV_N = 24;

    typedef struct packed {
        logic               vld;
        logic [COORD_W-1:0] col;
        logic [DEPTH_W-1:0] z;
        logic               flag;
    } t_tag;

    typedef struct packed {
        t_tag        tag;
        logic [63:0] v;
        logic [34:0] rem;
        logic [31:0] root;
    } t_sq;

    typedef struct packed {
        logic               vld;
        logic [COORD_W-1:0] col;
        logic               flag;
        logic               ovf;
        logic [55:0]        rem;
        logic [DV_N-1:0]    q;
    } t_dv;

    t_tag        r_m1, r_m2;
    logic [19:0] r_ad, r_fx1;
    logic [39:0] r_fx2, r_d2;
    t_sq         r_sq [SQ_N+1];
    t_dv         r_mu;
    t_dv         r_dv [DV_N+1];
    t_scan       r_out;

    logic signed [20:0] w_d;
    logic [55:0]        w_div;

    assign w_d   = signed'({1'b0, i_res.col, 8'b0}) - signed'({1'b0, i_cfg.center_x});
    assign w_div = 56'({i_cfg.focal_x, 11'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1.vld    <= 1'b0;
            r_m2.vld    <= 1'b0;
            r_sq[0].tag.vld <= 1'b0;
            r_mu.vld    <= 1'b0;
            r_out.vld   <= 1'b0;
        end else if (i_en) begin
            r_m1.vld    <= i_res.vld;
            r_m2.vld    <= r_m1.vld;
            r_sq[0].tag.vld <= r_m2.vld;
            r_mu.vld    <= r_sq[SQ_N].tag.vld;
            r_out.vld   <= r_dv[DV_N].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1.col  <= i_res.col;
            r_m1.z    <= i_res.depth;
            r_m1.flag <= i_res.ok && (i_cfg.focal_x != '0);
            r_ad      <= w_d[20] ? 20'(-w_d) : w_d[19:0];
            r_fx1     <= i_cfg.focal_x;
            r_m2.col  <= r_m1.col;
            r_m2.z    <= r_m1.z;
            r_m2.flag <= r_m1.flag;
            r_fx2     <= r_fx1 * r_fx1;
            r_d2      <= r_ad * r_ad;
            r_sq[0].tag.col  <= r_m2.col;
            r_sq[0].tag.z    <= r_m2.z;
            r_sq[0].tag.flag <= r_m2.flag;
            r_sq[0].v        <= {1'b0, 41'(r_fx2) + 41'(r_d2), 22'b0};
            r_sq[0].rem      <= '0;
            r_sq[0].root     <= '0;
            r_mu.col  <= r_sq[SQ_N].tag.col;
            r_mu.flag <= r_sq[SQ_N].tag.flag;
            r_mu.ovf  <= 1'b0;
            r_mu.rem  <= r_sq[SQ_N].tag.z * r_sq[SQ_N].root;
            r_mu.q    <= '0;
            r_out.col   <= r_dv[DV_N].col;
            r_out.fin   <= r_dv[DV_N].flag && !r_dv[DV_N].ovf
                           && (r_dv[DV_N].q <= i_cfg.depth_hi);
            r_out.range <= (r_dv[DV_N].flag && !r_dv[DV_N].ovf
                           && (r_dv[DV_N].q <= i_cfg.depth_hi)) ? r_dv[DV_N].q : '0;
        end
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_sq
        logic [34:0] w_rem, w_trial;
        logic        w_ge;
        always_comb begin
            w_rem   = {r_sq[k].rem[32:0], r_sq[k].v[63:62]};
            w_trial = {1'b0, r_sq[k].root, 2'b01};
            w_ge    = (w_rem >= w_trial);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[k+1].tag.vld <= 1'b0;
            end else if (i_en) begin
                r_sq[k+1].tag.vld <= r_sq[k].tag.vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k+1].tag.col  <= r_sq[k].tag.col;
                r_sq[k+1].tag.z    <= r_sq[k].tag.z;
                r_sq[k+1].tag.flag <= r_sq[k].tag.flag;
                r_sq[k+1].v    <= {r_sq[k].v[61:0], 2'b00};
                r_sq[k+1].rem  <= w_ge ? (w_rem - w_trial) : w_rem;
                r_sq[k+1].root <= {r_sq[k].root[30:0], w_ge};
            end
        end
    end

    always_comb begin
        r_dv[0] = r_mu;
    end

    for (genvar i = 0; i < DV_N; i++) begin : g_dv
        logic [55:0] w_sh;
        logic        w_ge, w_ovf;
        always_comb begin
            w_sh = w_div << (DV_N - 1 - i);
            w_ge = (r_dv[i].rem >= w_sh);
        end
        if (i == 0) begin : g_ovf
            assign w_ovf = (r_dv[i].rem >= (w_div << DV_N));
        end else begin : g_pass
            assign w_ovf = r_dv[i].ovf;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[i+1].vld <= 1'b0;
            end else if (i_en) begin
                r_dv[i+1].vld <= r_dv[i].vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[i+1].col  <= r_dv[i].col;
                r_dv[i+1].flag <= r_dv[i].flag;
                r_dv[i+1].ovf  <= w_ovf;
                r_dv[i+1].rem  <= w_ge ? (r_dv[i].rem - w_sh) : r_dv[i].rem;
                r_dv[i+1].q    <= {r_dv[i].q[DV_N-2:0], w_ge};
            end
        end
    end

    assign o_scan = r_out;
endmodule
`default_nettype wire

[src/depth_strip_to_range_scan.sv]
// Throughput: one input beat per cycle while the two-entry output buffer is not full;
// column state is a read-modify-write of one synchronous RAM with write forwarding,
// and the range math is a fully pipelined sqrt and divider. The output buffer holds
// results while m_axis stalls. Reset (i_rst_n low, synchronous) restores the
// configuration registers and empties the pipeline; the column RAM is not cleared.
`default_nettype none
module depth_strip_to_range_scan #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dsrs_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [dsrs_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [47:0]                   s_axis_tdata,  // pixel_row, pixel_col, depth_value
    input  logic [0:0]                    s_axis_tuser,  // depth_finite
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,  // scan_column, scan_range, zero pad
    output logic [0:0]                    m_axis_tuser   // range_finite
);
    import dsrs_pkg::*;

    t_cfg     r_cfg;
    t_col_res w_res;
    t_scan    w_scan;
    t_scan    r_buf [2];
    logic [1:0] r_cnt;
    logic       r_wr, r_rd;
    logic       w_en, w_push, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x      <= FOCAL_X_RST;
            r_cfg.center_x     <= CENTER_X_RST;
            r_cfg.strip_height <= STRIP_HEIGHT_RST;
            r_cfg.strip_row    <= STRIP_ROW_AUTO;
            r_cfg.image_height <= IMAGE_HEIGHT_RST;
            r_cfg.depth_lo     <= DEPTH_LO_RST;
            r_cfg.depth_hi     <= DEPTH_HI_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FOCAL_X:      r_cfg.focal_x      <= i_cfg_wdata[FX_W-1:0];
                CFG_CENTER_X:     r_cfg.center_x     <= i_cfg_wdata[FX_W-1:0];
                CFG_STRIP_HEIGHT: r_cfg.strip_height <= i_cfg_wdata[ROWS_W-1:0];
                CFG_STRIP_ROW:    r_cfg.strip_row    <= signed'(i_cfg_wdata[ROWS_W-1:0]);
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_wdata[ROWS_W-1:0];
                CFG_DEPTH_LO:     r_cfg.depth_lo     <= i_cfg_wdata[DEPTH_W-1:0];
                CFG_DEPTH_HI:     r_cfg.depth_hi     <= i_cfg_wdata[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_en          = (r_cnt != 2'd2);
    assign s_axis_tready = w_en;

    dsrs_column #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_column (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .i_row   (s_axis_tdata[11:0]),
        .i_col   (s_axis_tdata[23:12]),
        .i_depth (s_axis_tdata[47:24]),
        .i_fin   (s_axis_tuser[0]),
        .o_res   (w_res)
    );

    dsrs_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_res   (w_res),
        .o_scan  (w_scan)
    );

    assign w_push = w_en && w_scan.vld;
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= w_scan;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {4'b0, r_buf[r_rd].range, r_buf[r_rd].col};
    assign m_axis_tuser  = r_buf[r_rd].fin;
endmodule
`default_nettype wire

[src/dsrs_checker.sv]
`default_nettype none
module dsrs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [39:0]                 m_axis_tdata,
    input logic [0:0]                  m_axis_tuser
);
    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[35:12] == 24'd0))
        else $error("infinite range beat carries nonzero range");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:36] == 4'd0))
        else $error("output pad bits nonzero");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not empty and ready after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output beat changed");
endmodule

bind depth_strip_to_range_scan dsrs_checker u_dsrs_checker (.*);
`default_nettype wire
